// ===== src/tidht_pkg.sv =====
// ----------------------------------------------------------------------------
// tidht_pkg: shared types and constants for the thread ID handle table
// Field widths, command codes, table entry layout and the control/status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tidht_pkg;

  // Fixed field widths and default table depth
  localparam int ID_W          = 16;
  localparam int HND_W         = 32;
  localparam int DEPTH_DEFAULT = 256;

  // Operation codes on the cmd field
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } tidht_op_t;

  // One table slot
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [HND_W-1:0] handle;
  } tidht_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // capture input transfer
    logic clr_step;   // clear one slot of the table
    logic slot_calc;  // reduce thread ID to a slot index
    logic alloc_init; // set up candidate from search start
    logic rd_cand;    // read at candidate slot, else at ID slot
    logic alloc_chk;  // test candidate, claim or advance
    logic req_chk;    // finish free or lookup
    logic res_bad;    // unused command result
    logic load_out;   // move result into output register
  } tidht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic      clr_last;
    tidht_op_t op;
    logic      slot_free;
    logic      cnt_last;
    logic      out_free;
  } tidht_stat_t;

endpackage

`default_nettype wire

// ===== src/thread_id_handle_table_core.sv =====
// ----------------------------------------------------------------------------
// thread_id_handle_table_core: next-fit thread ID allocator with handle slots
// Input channel (in_valid/in_stall) carries cmd, thread_id and handle; the
// output channel (out_valid/out_stall) carries status, id_out, handle_out.
// One result per command. A transfer happens when valid is high and stall is
// low. Commands are worked one at a time out of a slot memory with one read
// and one write port; lookup/free decode, then read and check the ID slot;
// allocate decodes, then reads and checks up to TABLE_DEPTH candidates,
// skipping occupied slots; an unused cmd goes from decode to the result.
// The next command is taken in the cycle after the result is loaded.
// Each candidate slot costs a memory read and a check. The output register
// parts the two sides: a new command is taken while a result waits, and that
// command holds in its last step until the output register is free. While
// out_stall is high the output payload holds.
// After reset the slot memory is cleared, one slot a cycle; in_stall stays
// high during the pass. The search start resets to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module thread_id_handle_table_core #(
  parameter int TABLE_DEPTH = tidht_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  cmd,
  input  wire logic [tidht_pkg::ID_W-1:0]  thread_id,
  input  wire logic [tidht_pkg::HND_W-1:0] handle,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             status,
  output logic [tidht_pkg::ID_W-1:0]       id_out,
  output logic [tidht_pkg::HND_W-1:0]      handle_out
);

  tidht_pkg::tidht_cmd_t  dp_cmd;
  tidht_pkg::tidht_stat_t dp_stat;

  // Sequencer
  tidht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Table and result path
  tidht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .cmd_in     (cmd),
    .thread_id  (thread_id),
    .handle     (handle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .id_out     (id_out),
    .handle_out (handle_out)
  );

endmodule

`default_nettype wire

// ===== src/tidht_ctrl.sv =====
// ----------------------------------------------------------------------------
// tidht_ctrl: sequencer for the thread ID handle table
// Runs the clearing pass after reset, then steps each command through the
// datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tidht_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire tidht_pkg::tidht_stat_t stat,
  output tidht_pkg::tidht_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ARD,
    ST_ACHK,
    ST_RD,
    ST_CHK,
    ST_FIN
  } state_t;

  state_t state, state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.slot_calc = 1'b1;
        case (stat.op)
          tidht_pkg::CMD_ALLOC: begin
            cmd.alloc_init = 1'b1;
            state_next     = ST_ARD;
          end
          tidht_pkg::CMD_FREE, tidht_pkg::CMD_LOOKUP: begin
            state_next = ST_RD;
          end
          default: begin
            cmd.res_bad = 1'b1;
            state_next  = ST_FIN;
          end
        endcase
      end
      ST_ARD: begin
        cmd.rd_cand = 1'b1;
        state_next  = ST_ACHK;
      end
      ST_ACHK: begin
        cmd.alloc_chk = 1'b1;
        if (stat.slot_free || stat.cnt_last) state_next = ST_FIN;
        else state_next = ST_ARD;
      end
      ST_RD: begin
        state_next = ST_CHK;
      end
      ST_CHK: begin
        cmd.req_chk = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        cmd.load_out = stat.out_free;
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tidht_dp.sv =====
// ----------------------------------------------------------------------------
// tidht_dp: datapath of the thread ID handle table
// Slot memory, slot index reduction, next-fit candidate tracking, search
// start register and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tidht_dp #(
  parameter int TABLE_DEPTH = tidht_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tidht_pkg::tidht_cmd_t       cmd,
  output tidht_pkg::tidht_stat_t           stat,
  input  wire logic [1:0]                  cmd_in,
  input  wire logic [tidht_pkg::ID_W-1:0]  thread_id,
  input  wire logic [tidht_pkg::HND_W-1:0] handle,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             status,
  output logic [tidht_pkg::ID_W-1:0]       id_out,
  output logic [tidht_pkg::HND_W-1:0]      handle_out
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  // ceil(2^32 / depth): exact quotient for every 16-bit ID
  localparam logic [63:0] RECIP = ((64'd1 << 32) + 64'(TABLE_DEPTH) - 64'd1)
                                  / 64'(TABLE_DEPTH);
  localparam logic [tidht_pkg::ID_W-1:0] ID_TOP = '1;

  tidht_pkg::tidht_entry_t mem [TABLE_DEPTH];
  tidht_pkg::tidht_entry_t rd_data;
  tidht_pkg::tidht_entry_t wr_data;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  logic                    wr_en;

  // Captured request
  tidht_pkg::tidht_op_t           op_r;
  logic [tidht_pkg::ID_W-1:0]     tid_r;
  logic [tidht_pkg::HND_W-1:0]    hnd_r;
  logic [47:0]                    prod;
  logic [31:0]                    rem_full;
  logic [IDX_W-1:0]               slot_r;

  // Search state
  logic [tidht_pkg::ID_W-1:0]     cand, start_id;
  logic [IDX_W-1:0]               cand_slot, start_slot, count, clr_addr;

  // Result
  logic                           res_status;
  logic [tidht_pkg::ID_W-1:0]     res_id;
  logic [tidht_pkg::HND_W-1:0]    res_handle;
  logic                           hit;

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    slot_inc = (s == IDX_MAX) ? '0 : s + IDX_ONE;
  endfunction

  // Status back to the controller
  always_comb begin
    stat.clr_last  = (clr_addr == IDX_MAX);
    stat.op        = op_r;
    stat.slot_free = !rd_data.valid;
    stat.cnt_last  = (count == IDX_MAX);
    stat.out_free  = !out_valid || !out_stall;
  end

  assign hit = (tid_r != '0) && rd_data.valid && (rd_data.id == tid_r);

  // Remainder from registered quotient
  assign rem_full = 32'(tid_r) - 32'(prod[47:32]) * 32'(TABLE_DEPTH);

  // Memory port selection
  assign rd_addr = cmd.rd_cand ? cand_slot : slot_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_chk && !rd_data.valid) begin
      wr_en          = 1'b1;
      wr_addr        = cand_slot;
      wr_data.valid  = 1'b1;
      wr_data.id     = cand;
      wr_data.handle = hnd_r;
    end else if (cmd.req_chk && (op_r == tidht_pkg::CMD_FREE)) begin
      wr_en   = 1'b1;
      wr_addr = slot_r;
    end
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= slot_inc(clr_addr);
    end
  end

  // Request capture and slot reduction
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= tidht_pkg::tidht_op_t'(cmd_in);
      tid_r <= thread_id;
      hnd_r <= handle;
      prod  <= 48'(thread_id) * 48'(RECIP[31:0]);
    end
    if (cmd.slot_calc) slot_r <= rem_full[IDX_W-1:0];
  end

  // Search start, kept with its slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      start_id   <= '0;
      start_slot <= '0;
    end else if (cmd.alloc_chk && !rd_data.valid) begin
      start_id   <= cand + 1'b1;
      start_slot <= (cand == ID_TOP) ? '0 : slot_inc(cand_slot);
    end
  end

  // Candidate walk and result
  always_ff @(posedge clk) begin
    if (cmd.alloc_init) begin
      count <= '0;
      if (start_id == '0) begin
        cand      <= tidht_pkg::ID_W'(1);
        cand_slot <= IDX_ONE;
      end else begin
        cand      <= start_id;
        cand_slot <= start_slot;
      end
    end
    if (cmd.alloc_chk) begin
      if (!rd_data.valid) begin
        res_status <= 1'b0;
        res_id     <= cand;
        res_handle <= '0;
      end else begin
        res_status <= 1'b1;
        res_id     <= '0;
        res_handle <= '0;
        count      <= count + IDX_ONE;
        // wrap past the top ID to 1, skipping 0
        if (cand == ID_TOP) begin
          cand      <= tidht_pkg::ID_W'(1);
          cand_slot <= IDX_ONE;
        end else begin
          cand      <= cand + 1'b1;
          cand_slot <= slot_inc(cand_slot);
        end
      end
    end
    if (cmd.req_chk) begin
      res_id     <= tid_r;
      res_handle <= ((op_r == tidht_pkg::CMD_LOOKUP) && hit) ? rd_data.handle : '0;
      case (op_r)
        tidht_pkg::CMD_FREE:   res_status <= 1'b0;
        tidht_pkg::CMD_LOOKUP: res_status <= !hit;
        default:               res_status <= 1'b1;
      endcase
    end
    if (cmd.res_bad) begin
      res_status <= 1'b1;
      res_id     <= tid_r;
      res_handle <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= res_status;
      id_out     <= res_id;
      handle_out <= res_handle;
    end
  end

endmodule

`default_nettype wire
